### rtl/kded_pkg.sv
// ----------------------------------------------------------------------------
// kded_pkg
// Shared types, codes and reset values of the key debounce event detector.
// ----------------------------------------------------------------------------
package kded_pkg;

    localparam int TIME_BITS     = 32;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam int MASK_BITS     = 7;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [TIME_BITS-1:0] DEF_DEBOUNCE_TIME   = TIME_BITS'(20);
    localparam logic [TIME_BITS-1:0] DEF_LONG_PRESS_TIME = TIME_BITS'(1000);
    localparam logic [TIME_BITS-1:0] DEF_MAX_HOLD_TIME   = '0;
    localparam logic [MASK_BITS-1:0] DEF_EVENT_MASK      = '1;

    typedef enum logic [1:0] {
        OP_POLL    = 2'd0,
        OP_SYNC    = 2'd1,
        OP_DISABLE = 2'd2,
        OP_ENABLE  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOT_INIT = 2'd1,
        ST_DISABLED = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        EV_PRESS   = 3'd0,
        EV_RELEASE = 3'd1,
        EV_SHORT   = 3'd2,
        EV_LONG    = 3'd3,
        EV_STUCK   = 3'd4,
        EV_ON      = 3'd5,
        EV_OFF     = 3'd6
    } event_code_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_IS_SWITCH      = 3'd0,
        REG_ACTIVE_HIGH    = 3'd1,
        REG_DEBOUNCE_TIME  = 3'd2,
        REG_LONG_PRESS     = 3'd3,
        REG_MAX_HOLD       = 3'd4,
        REG_EVENT_MASK     = 3'd5,
        REG_REPORT_INITIAL = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic                 is_switch;
        logic                 active_high;
        logic [TIME_BITS-1:0] debounce_time;
        logic [TIME_BITS-1:0] long_press_time;
        logic [TIME_BITS-1:0] max_hold_time;
        logic [MASK_BITS-1:0] event_enable_mask;
        logic                 report_initial;
    } cfg_t;

    typedef struct packed {
        logic [1:0]           opcode;
        logic                 pin_level;
        logic [TIME_BITS-1:0] now_time;
    } in_t;

    typedef struct packed {
        logic [1:0]           status;
        logic                 event_valid;
        logic [2:0]           event_code;
        logic [TIME_BITS-1:0] event_time;
        logic [TIME_BITS-1:0] hold_duration;
        logic                 last_result;
        logic                 stable_pressed;
        logic                 raw_level_seen;
    } out_t;

    // one classified request as it travels from front to back
    typedef struct packed {
        logic [1:0]           status;
        logic [1:0]           ev_count;
        logic [2:0]           code0;
        logic [2:0]           code1;
        logic [TIME_BITS-1:0] dur0;
        logic [TIME_BITS-1:0] dur1;
        logic [TIME_BITS-1:0] now_time;
        logic                 stable_pressed;
        logic                 pin_seen;
    } rec_t;

endpackage

### rtl/kded_cfg_regs.sv
// ----------------------------------------------------------------------------
// kded_cfg_regs
// Configuration register file written through its own valid/ready channel.
// ----------------------------------------------------------------------------
module kded_cfg_regs
    import kded_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    output cfg_t                     cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_IS_SWITCH:      cfg_next.is_switch         = cfg_wdata[0];
                REG_ACTIVE_HIGH:    cfg_next.active_high       = cfg_wdata[0];
                REG_DEBOUNCE_TIME:  cfg_next.debounce_time     = cfg_wdata[TIME_BITS-1:0];
                REG_LONG_PRESS:     cfg_next.long_press_time   = cfg_wdata[TIME_BITS-1:0];
                REG_MAX_HOLD:       cfg_next.max_hold_time     = cfg_wdata[TIME_BITS-1:0];
                REG_EVENT_MASK:     cfg_next.event_enable_mask = cfg_wdata[MASK_BITS-1:0];
                REG_REPORT_INITIAL: cfg_next.report_initial    = cfg_wdata[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.is_switch         <= 1'b0;
            cfg_reg.active_high       <= 1'b0;
            cfg_reg.debounce_time     <= DEF_DEBOUNCE_TIME;
            cfg_reg.long_press_time   <= DEF_LONG_PRESS_TIME;
            cfg_reg.max_hold_time     <= DEF_MAX_HOLD_TIME;
            cfg_reg.event_enable_mask <= DEF_EVENT_MASK;
            cfg_reg.report_initial    <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### rtl/kded_front.sv
// ----------------------------------------------------------------------------
// kded_front
// Accepts requests, runs the debounce and hold state and classifies events.
// ----------------------------------------------------------------------------
module kded_front
    import kded_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  cfg_t cfg,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    input  logic q_full,
    output logic push,
    output rec_t push_rec
);

    logic                 init_reg, init_next;
    logic                 enabled_reg, enabled_next;
    logic                 cur_level_reg, cur_level_next;
    logic                 last_level_reg, last_level_next;
    logic                 stable_reg, stable_next;
    logic                 pressed_reg, pressed_next;
    logic [TIME_BITS-1:0] change_time_reg, change_time_next;
    logic [TIME_BITS-1:0] press_time_reg, press_time_next;
    logic                 long_rep_reg, long_rep_next;
    logic                 stuck_rep_reg, stuck_rep_next;

    logic                 pin;
    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] dur;
    logic [TIME_BITS-1:0] since_change;
    logic                 cand, settled, commit_press, commit_release;
    logic                 long_hit, stuck_hit, sync_pressed;
    logic                 a_v, b_v, a_ok, b_ok;
    logic [2:0]           a_code, b_code;
    logic [TIME_BITS-1:0] a_dur, b_dur;
    logic [1:0]           status;

    assign s_ready = !q_full;
    assign push    = s_valid && !q_full;

    assign pin          = s_data.pin_level;
    assign now          = s_data.now_time;
    assign dur          = now - press_time_reg;
    assign since_change = now - change_time_reg;
    assign cand         = (pin == cfg.active_high);
    assign sync_pressed = cand;

    // a fresh raw change restarts the debounce window at zero
    assign settled = (pin != last_level_reg) ? (cfg.debounce_time == '0)
                                             : (since_change >= cfg.debounce_time);
    assign commit_press   = (pin != stable_reg) && settled && cand && !pressed_reg;
    assign commit_release = (pin != stable_reg) && settled && !cand && pressed_reg;

    assign long_hit  = !cfg.is_switch && !long_rep_reg && (dur >= cfg.long_press_time);
    assign stuck_hit = (cfg.max_hold_time != '0) && !stuck_rep_reg
                       && (dur >= cfg.max_hold_time);

    always_comb begin
        init_next        = init_reg;
        enabled_next     = enabled_reg;
        cur_level_next   = cur_level_reg;
        last_level_next  = last_level_reg;
        stable_next      = stable_reg;
        pressed_next     = pressed_reg;
        change_time_next = change_time_reg;
        press_time_next  = press_time_reg;
        long_rep_next    = long_rep_reg;
        stuck_rep_next   = stuck_rep_reg;
        status           = ST_OK;
        a_v    = 1'b0;
        a_code = EV_PRESS;
        a_dur  = '0;
        b_v    = 1'b0;
        b_code = EV_PRESS;
        b_dur  = '0;

        if (s_data.opcode == OP_SYNC) begin
            cur_level_next   = pin;
            last_level_next  = pin;
            stable_next      = pin;
            pressed_next     = sync_pressed;
            change_time_next = now;
            press_time_next  = now;
            long_rep_next    = !cfg.is_switch && sync_pressed;
            stuck_rep_next   = !cfg.is_switch && sync_pressed;
            enabled_next     = 1'b1;
            init_next        = 1'b1;
            a_v    = cfg.is_switch && cfg.report_initial;
            a_code = sync_pressed ? EV_ON : EV_OFF;
        end else if (!init_reg) begin
            status = ST_NOT_INIT;
        end else if (s_data.opcode == OP_DISABLE) begin
            enabled_next   = 1'b0;
            long_rep_next  = 1'b0;
            stuck_rep_next = 1'b0;
        end else if (s_data.opcode == OP_ENABLE) begin
            enabled_next = 1'b1;
        end else if (!enabled_reg) begin
            status = ST_DISABLED;
        end else begin
            cur_level_next = pin;
            if (pin != last_level_reg) begin
                change_time_next = now;
                last_level_next  = pin;
            end
            if (pin == stable_reg) begin
                change_time_next = now;
            end else if (settled) begin
                stable_next = pin;
            end
            if (commit_press) begin
                pressed_next    = 1'b1;
                press_time_next = now;
                a_v    = 1'b1;
                a_code = cfg.is_switch ? EV_ON : EV_PRESS;
                // zero long press time: a button's long press follows the press at once
                b_v           = !cfg.is_switch && (cfg.long_press_time == '0);
                b_code        = EV_LONG;
                long_rep_next = b_v;
                stuck_rep_next = 1'b0;
            end else if (commit_release) begin
                pressed_next   = 1'b0;
                long_rep_next  = 1'b0;
                stuck_rep_next = 1'b0;
                if (cfg.is_switch) begin
                    a_v    = 1'b1;
                    a_code = EV_OFF;
                    a_dur  = dur;
                end else begin
                    a_v    = !long_rep_reg;
                    a_code = EV_SHORT;
                    a_dur  = dur;
                    b_v    = 1'b1;
                    b_code = EV_RELEASE;
                    b_dur  = dur;
                end
            end else if (pressed_reg) begin
                a_v    = long_hit;
                a_code = EV_LONG;
                a_dur  = dur;
                b_v    = stuck_hit;
                b_code = EV_STUCK;
                b_dur  = dur;
                if (long_hit) begin
                    long_rep_next = 1'b1;
                end
                if (stuck_hit) begin
                    stuck_rep_next = 1'b1;
                end
            end
        end
    end

    assign a_ok = a_v && cfg.event_enable_mask[a_code];
    assign b_ok = b_v && cfg.event_enable_mask[b_code];

    always_comb begin
        push_rec.status         = status;
        push_rec.now_time       = now;
        push_rec.stable_pressed = init_next && pressed_next;
        push_rec.pin_seen       = init_next && cur_level_next;
        push_rec.code1          = b_code;
        push_rec.dur1           = b_dur;
        if (a_ok) begin
            push_rec.ev_count = b_ok ? 2'd2 : 2'd1;
            push_rec.code0    = a_code;
            push_rec.dur0     = a_dur;
        end else begin
            push_rec.ev_count = b_ok ? 2'd1 : 2'd0;
            push_rec.code0    = b_code;
            push_rec.dur0     = b_dur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_reg        <= 1'b0;
            enabled_reg     <= 1'b0;
            cur_level_reg   <= 1'b0;
            last_level_reg  <= 1'b0;
            stable_reg      <= 1'b0;
            pressed_reg     <= 1'b0;
            change_time_reg <= '0;
            press_time_reg  <= '0;
            long_rep_reg    <= 1'b0;
            stuck_rep_reg   <= 1'b0;
        end else if (push) begin
            init_reg        <= init_next;
            enabled_reg     <= enabled_next;
            cur_level_reg   <= cur_level_next;
            last_level_reg  <= last_level_next;
            stable_reg      <= stable_next;
            pressed_reg     <= pressed_next;
            change_time_reg <= change_time_next;
            press_time_reg  <= press_time_next;
            long_rep_reg    <= long_rep_next;
            stuck_rep_reg   <= stuck_rep_next;
        end
    end

endmodule

### rtl/kded_queue.sv
// ----------------------------------------------------------------------------
// kded_queue
// Short first-in first-out queue of classified requests.
// ----------------------------------------------------------------------------
module kded_queue
    import kded_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  rec_t push_rec,
    output logic full,
    input  logic pop,
    output logic empty,
    output rec_t head
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    rec_t             mem_reg [DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == FULL_CNT);
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/kded_back.sv
// ----------------------------------------------------------------------------
// kded_back
// Expands each queued request into its results and drives the output register.
// ----------------------------------------------------------------------------
module kded_back
    import kded_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic empty,
    input  rec_t head,
    output logic pop,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    logic sel_reg, sel_next;
    logic m_valid_reg, m_valid_next;
    out_t m_data_reg, m_data_next;
    logic load, has_ev, last;

    assign load   = !m_valid_reg || m_ready;
    assign has_ev = (head.ev_count != 2'd0);
    // second result only when two events survived the mask
    assign last   = (head.ev_count != 2'd2) || sel_reg;
    assign pop    = load && !empty && last;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        sel_next     = sel_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (load) begin
            m_valid_next = !empty;
            if (!empty) begin
                sel_next                   = !last;
                m_data_next.status         = head.status;
                m_data_next.event_valid    = has_ev;
                m_data_next.event_code     = !has_ev ? 3'd0 : (sel_reg ? head.code1 : head.code0);
                m_data_next.event_time     = has_ev ? head.now_time : '0;
                m_data_next.hold_duration  = !has_ev ? '0 : (sel_reg ? head.dur1 : head.dur0);
                m_data_next.last_result    = last;
                m_data_next.stable_pressed = head.stable_pressed;
                m_data_next.raw_level_seen = head.pin_seen;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            sel_reg     <= sel_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

### rtl/key_debounce_event_detector.sv
// ----------------------------------------------------------------------------
// key_debounce_event_detector
// Debounces one pin and reports button or switch events with hold times.
// ----------------------------------------------------------------------------
// Requests enter on s_valid/s_ready/s_data: poll, sync, disable or enable,
// each with a pin sample and a millisecond timestamp. Every request gives one
// or two results on m_valid/m_ready/m_data; last_result marks the final one.
// Configuration is written on cfg_valid/cfg_ready with cfg_index and
// cfg_wdata; the user must write it only while the block is idle, which the
// block itself does not enforce. cfg_ready is always high.
// The front classifies a request in the cycle it is accepted and pushes it
// into a two-entry queue; the back expands it into results behind an output
// register. Throughput is one request per cycle while m_ready stays high,
// bounded by the single output port, which a two-event request uses twice.
// Reset clears all debounce state, empties the queue and loads the default
// configuration; polls before the first sync answer not initialised.
// When the receiver stalls, the output holds, the queue fills and s_ready
// drops once it holds two requests.
// ----------------------------------------------------------------------------
module key_debounce_event_detector
    import kded_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  in_t                      s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output out_t                     m_data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

    cfg_t cfg;
    logic push, q_full, q_empty, pop;
    rec_t push_rec, head;

    kded_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    kded_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_full   (q_full),
        .push     (push),
        .push_rec (push_rec)
    );

    kded_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_rec (push_rec),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .head     (head)
    );

    kded_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .empty   (q_empty),
        .head    (head),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

### tb/kded_event_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kded_event_checker
// Watches the request, result and register channels of the key debounce
// event detector. Keeps its own copy of the debounce state and settings,
// works out the results of every accepted request and compares each result
// field by field with the oldest one still expected.
// ----------------------------------------------------------------------------
module kded_event_checker
    import kded_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  in_t                      s_data,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  out_t                     m_data,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    output int                       mismatch_count,
    output int                       pending_results,
    output int                       requests_seen,
    output int                       results_checked,
    output int                       events_seen
);

    localparam int PRINT_CAP = 50;

    cfg_t                 key_cfg;
    logic                 initialised;
    logic                 enabled;
    logic                 cur_level;
    logic                 last_sample;
    logic                 stable_level;
    logic                 pressed;
    logic [TIME_BITS-1:0] change_ms;
    logic [TIME_BITS-1:0] press_ms;
    logic                 long_done;
    logic                 stuck_done;

    // events raised by the request being predicted
    event_code_t          step_codes [2];
    logic [TIME_BITS-1:0] step_durs [2];
    int                   step_count;

    out_t                 expected_results [$];

    task automatic log_failure(input string msg);
        if (mismatch_count < PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string field, input logic [TIME_BITS-1:0] got,
                                 input logic [TIME_BITS-1:0] want);
        if (got !== want)
            log_failure($sformatf("result %0d: %s is %0h, expected %0h",
                                  results_checked, field, got, want));
    endtask

    function automatic logic level_is_pressed(input logic lvl);
        return lvl == key_cfg.active_high;
    endfunction

    task automatic raise_event(input event_code_t code, input logic [TIME_BITS-1:0] dur);
        if (key_cfg.event_enable_mask[code] && step_count < 2) begin
            step_codes[step_count] = code;
            step_durs[step_count]  = dur;
            step_count++;
        end
    endtask

    task automatic settle_press_state(input logic np, input logic [TIME_BITS-1:0] now);
        logic [TIME_BITS-1:0] dur;
        if (np != pressed) begin
            pressed      = np;
            stable_level = np ? key_cfg.active_high : !key_cfg.active_high;
            if (np) begin
                press_ms   = now;
                long_done  = 1'b0;
                stuck_done = 1'b0;
                raise_event(key_cfg.is_switch ? EV_ON : EV_PRESS, '0);
            end else begin
                dur = now - press_ms;
                if (!key_cfg.is_switch) begin
                    if (!long_done)
                        raise_event(EV_SHORT, dur);
                    raise_event(EV_RELEASE, dur);
                end else begin
                    raise_event(EV_OFF, dur);
                end
                long_done  = 1'b0;
                stuck_done = 1'b0;
            end
        end
    endtask

    task automatic check_hold_timers(input logic [TIME_BITS-1:0] now);
        logic [TIME_BITS-1:0] dur;
        if (pressed) begin
            dur = now - press_ms;
            if (!key_cfg.is_switch && !long_done && dur >= key_cfg.long_press_time) begin
                long_done = 1'b1;
                raise_event(EV_LONG, dur);
            end
            if (key_cfg.max_hold_time != '0 && !stuck_done && dur >= key_cfg.max_hold_time) begin
                stuck_done = 1'b1;
                raise_event(EV_STUCK, dur);
            end
        end
    endtask

    task automatic predict_request(input in_t req);
        status_t              st;
        logic [TIME_BITS-1:0] now;
        logic [TIME_BITS-1:0] since_change;
        logic                 pin;
        out_t                 res;
        int                   n;
        now        = req.now_time;
        pin        = req.pin_level;
        st         = ST_OK;
        step_count = 0;
        if (req.opcode == OP_SYNC) begin
            cur_level    = pin;
            last_sample  = pin;
            stable_level = pin;
            pressed      = level_is_pressed(pin);
            change_ms    = now;
            press_ms     = now;
            // a button already held at sync must not fire long or stuck
            long_done    = !key_cfg.is_switch && pressed;
            stuck_done   = !key_cfg.is_switch && pressed;
            enabled      = 1'b1;
            initialised  = 1'b1;
            if (key_cfg.is_switch && key_cfg.report_initial)
                raise_event(pressed ? EV_ON : EV_OFF, '0);
        end else if (!initialised) begin
            st = ST_NOT_INIT;
        end else if (req.opcode == OP_DISABLE) begin
            enabled    = 1'b0;
            long_done  = 1'b0;
            stuck_done = 1'b0;
        end else if (req.opcode == OP_ENABLE) begin
            enabled = 1'b1;
        end else if (!enabled) begin
            st = ST_DISABLED;
        end else begin
            cur_level = pin;
            if (pin != last_sample) begin
                change_ms   = now;
                last_sample = pin;
            end
            if (pin != stable_level) begin
                since_change = now - change_ms;
                if (since_change >= key_cfg.debounce_time) begin
                    stable_level = pin;
                    settle_press_state(level_is_pressed(pin), now);
                end
            end else begin
                change_ms = now;
            end
            check_hold_timers(now);
        end

        n = (step_count != 0) ? step_count : 1;
        for (int k = 0; k < n; k++) begin
            res                = '0;
            res.status         = st;
            res.event_valid    = step_count != 0;
            if (step_count != 0) begin
                res.event_code    = step_codes[k];
                res.event_time    = now;
                res.hold_duration = step_durs[k];
            end
            res.last_result    = (k == n - 1);
            res.stable_pressed = initialised && pressed;
            res.raw_level_seen = initialised && cur_level;
            expected_results.push_back(res);
        end
    endtask

    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            key_cfg.is_switch         = 1'b0;
            key_cfg.active_high       = 1'b0;
            key_cfg.debounce_time     = DEF_DEBOUNCE_TIME;
            key_cfg.long_press_time   = DEF_LONG_PRESS_TIME;
            key_cfg.max_hold_time     = DEF_MAX_HOLD_TIME;
            key_cfg.event_enable_mask = DEF_EVENT_MASK;
            key_cfg.report_initial    = 1'b0;
            initialised  = 1'b0;
            enabled      = 1'b0;
            cur_level    = 1'b0;
            last_sample  = 1'b0;
            stable_level = 1'b0;
            pressed      = 1'b0;
            change_ms    = '0;
            press_ms     = '0;
            long_done    = 1'b0;
            stuck_done   = 1'b0;
            expected_results.delete();
            mismatch_count  = 0;
            requests_seen   = 0;
            results_checked = 0;
            events_seen     = 0;
        end else begin
            // results first: a request accepted now cannot answer in the same cycle
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    log_failure($sformatf("result %0h arrived with nothing expected", m_data));
                end else begin
                    want = expected_results.pop_front();
                    compare_field("status", m_data.status, want.status);
                    compare_field("event_valid", m_data.event_valid, want.event_valid);
                    compare_field("event_code", m_data.event_code, want.event_code);
                    compare_field("event_time", m_data.event_time, want.event_time);
                    compare_field("hold_duration", m_data.hold_duration, want.hold_duration);
                    compare_field("last_result", m_data.last_result, want.last_result);
                    compare_field("stable_pressed", m_data.stable_pressed,
                                  want.stable_pressed);
                    compare_field("raw_level_seen", m_data.raw_level_seen,
                                  want.raw_level_seen);
                    results_checked++;
                    if (want.event_valid)
                        events_seen++;
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_IS_SWITCH:      key_cfg.is_switch         = cfg_wdata[0];
                    REG_ACTIVE_HIGH:    key_cfg.active_high       = cfg_wdata[0];
                    REG_DEBOUNCE_TIME:  key_cfg.debounce_time     = cfg_wdata;
                    REG_LONG_PRESS:     key_cfg.long_press_time   = cfg_wdata;
                    REG_MAX_HOLD:       key_cfg.max_hold_time     = cfg_wdata;
                    REG_EVENT_MASK:     key_cfg.event_enable_mask = cfg_wdata[MASK_BITS-1:0];
                    REG_REPORT_INITIAL: key_cfg.report_initial    = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                predict_request(s_data);
                requests_seen++;
            end
        end
        pending_results <= expected_results.size();
    end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the key debounce event detector. A directed
// opening walks through sync, debounce, press, long, short, release,
// switch reports, disable and timestamp wrap; then random phases of mostly polls
// with bouncing levels run under several register settings and idle patterns.
// ----------------------------------------------------------------------------
module tb;
    import kded_pkg::*;

    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;
    localparam logic [TIME_BITS-1:0]    TIME_MAX   = '1;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_valid   = 1'b0;
    logic                     s_ready;
    in_t                      s_data    = '0;
    logic                     m_valid;
    logic                     m_ready   = 1'b0;
    out_t                     m_data;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

    int mismatch_count;
    int pending_results;
    int requests_seen;
    int results_checked;
    int events_seen;

    int                   send_idle_pct = 16;
    int                   recv_idle_pct = 47;
    int                   settings_used = 0;
    cfg_t                 key_cfg;
    logic [TIME_BITS-1:0] sim_ms;
    logic                 key_target = 1'b0;

    key_debounce_event_detector dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    kded_event_checker u_event_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .requests_seen   (requests_seen),
        .results_checked (results_checked),
        .events_seen     (events_seen)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic cfg_t make_cfg(input logic sw, input logic ah,
                                      input logic [TIME_BITS-1:0] deb,
                                      input logic [TIME_BITS-1:0] lp,
                                      input logic [TIME_BITS-1:0] mh,
                                      input logic [MASK_BITS-1:0] mask,
                                      input logic rep);
        cfg_t c;
        c.is_switch         = sw;
        c.active_high       = ah;
        c.debounce_time     = deb;
        c.long_press_time   = lp;
        c.max_hold_time     = mh;
        c.event_enable_mask = mask;
        c.report_initial    = rep;
        return c;
    endfunction

    // handshakes are judged on the level seen at the falling edge before the rising edge
    task automatic issue(input opcode_t op, input logic pin, input logic [TIME_BITS-1:0] t);
        logic taken;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{opcode: op, pin_level: pin, now_time: t};
        do begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end while (!taken);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        logic taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        do begin
            @(negedge aclk);
            taken = cfg_ready;
            @(posedge aclk);
        end while (!taken);
    endtask

    task automatic wait_idle;
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_results != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic program_settings(input cfg_t c);
        wait_idle();
        write_reg(REG_UNUSED, $urandom);
        write_reg(REG_IS_SWITCH, CFG_DATA_BITS'(c.is_switch));
        write_reg(REG_ACTIVE_HIGH, CFG_DATA_BITS'(c.active_high));
        write_reg(REG_DEBOUNCE_TIME, c.debounce_time);
        write_reg(REG_LONG_PRESS, c.long_press_time);
        write_reg(REG_MAX_HOLD, c.max_hold_time);
        write_reg(REG_EVENT_MASK, CFG_DATA_BITS'(c.event_enable_mask));
        write_reg(REG_REPORT_INITIAL, CFG_DATA_BITS'(c.report_initial));
        cfg_valid <= 1'b0;
        key_cfg = c;
        settings_used++;
    endtask

    // mostly polls on a level that bounces before it settles, with time steps
    // clustered around the debounce, long press and stuck thresholds
    task automatic run_random_phase(input int count);
        int                   r;
        opcode_t              op;
        logic                 pin;
        logic [TIME_BITS-1:0] advance;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(99);
            if (r < 3)
                op = OP_SYNC;
            else if (r < 5)
                op = OP_DISABLE;
            else if (r < 11)
                op = OP_ENABLE;
            else
                op = OP_POLL;
            if ($urandom_range(9) == 0)
                key_target = !key_target;
            pin = ($urandom_range(7) == 0) ? !key_target : key_target;
            case ($urandom_range(6))
                0, 1:    advance = $urandom_range(0, 4);
                2:       advance = key_cfg.debounce_time + $urandom_range(0, 2) - 1;
                3:       advance = key_cfg.long_press_time + $urandom_range(0, 2) - 1;
                4:       advance = key_cfg.max_hold_time + $urandom_range(0, 2) - 1;
                default: advance = $urandom_range(0, 60);
            endcase
            sim_ms = sim_ms + advance;
            if ($urandom_range(24) == 0)
                sim_ms = $urandom;
            issue(op, pin, sim_ms);
        end
    endtask

    initial begin
        key_cfg = make_cfg(1'b0, 1'b0, DEF_DEBOUNCE_TIME, DEF_LONG_PRESS_TIME,
                           DEF_MAX_HOLD_TIME, DEF_EVENT_MASK, 1'b0);
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: button, pressed when low, 20 ms debounce, 1 s long press
        issue(OP_POLL, 1'b0, '0);
        issue(OP_ENABLE, 1'b1, TIME_MAX);
        issue(OP_DISABLE, 1'b0, 5);
        issue(OP_SYNC, 1'b1, 100);
        issue(OP_POLL, 1'b0, 110);
        issue(OP_POLL, 1'b0, 129);
        issue(OP_POLL, 1'b0, 130);
        issue(OP_POLL, 1'b0, 1130);
        issue(OP_POLL, 1'b1, 1200);
        issue(OP_POLL, 1'b1, 1220);
        issue(OP_POLL, 1'b0, 1300);
        issue(OP_POLL, 1'b0, 1320);
        issue(OP_POLL, 1'b1, 1400);
        // short press and release from one request
        issue(OP_POLL, 1'b1, 1420);
        issue(OP_DISABLE, 1'b1, 1500);
        issue(OP_POLL, 1'b0, 1510);
        issue(OP_ENABLE, 1'b1, 1520);
        // held at sync: no long press may follow
        issue(OP_SYNC, 1'b0, 2000);
        issue(OP_POLL, 1'b0, 5000);
        issue(OP_POLL, 1'b1, 5010);
        issue(OP_POLL, 1'b0, 5015);
        issue(OP_POLL, 1'b1, 5020);
        issue(OP_POLL, 1'b1, 5040);
        issue(OP_SYNC, 1'b1, 32'hFFFF_FFF0);
        issue(OP_POLL, 1'b0, TIME_MAX);
        issue(OP_POLL, 1'b0, 32'h0000_0013);

        // polarity flipped while pressed: level moves, pressed state stays
        program_settings(make_cfg(1'b1, 1'b1, '0, '0, 50, 7'h7F, 1'b1));
        issue(OP_POLL, 1'b0, 32'h0000_0020);
        issue(OP_POLL, 1'b1, 32'h0000_0060);
        issue(OP_POLL, 1'b0, 32'h0000_0070);
        issue(OP_SYNC, 1'b1, 32'h0000_0080);

        // longest debounce and zero long press time
        program_settings(make_cfg(1'b0, 1'b1, TIME_MAX, '0, '0, 7'h7F, 1'b0));
        issue(OP_SYNC, 1'b0, 200);
        issue(OP_POLL, 1'b1, 210);
        issue(OP_POLL, 1'b1, 209);
        sim_ms = 209;

        program_settings(make_cfg(1'b0, 1'b0, 20, 1000, '0, 7'h7F, 1'b0));
        run_random_phase(140);
        program_settings(make_cfg(1'b1, 1'b1, 5, 50, 300, 7'h7F, 1'b1));
        run_random_phase(140);

        send_idle_pct = 47;
        recv_idle_pct = 16;
        program_settings(make_cfg(1'b0, 1'b1, '0, 1, 1, 7'($urandom_range(0, 127)), 1'b0));
        run_random_phase(140);
        program_settings(make_cfg(1'b1, 1'b0, TIME_MAX, TIME_MAX, TIME_MAX, '0, 1'b1));
        run_random_phase(120);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        program_settings(make_cfg(1'b0, 1'b0, 3, '0, 10, 7'($urandom_range(0, 127)), 1'b0));
        run_random_phase(140);
        program_settings(make_cfg(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  $urandom_range(0, 30), $urandom_range(0, 200),
                                  $urandom_range(0, 1) ? $urandom_range(1, 400) : 0,
                                  7'($urandom_range(0, 127)), 1'($urandom_range(0, 1))));
        run_random_phase(140);

        s_valid <= 1'b0;
        for (int guard = 0; guard < 10000 && pending_results != 0; guard++)
            @(negedge aclk);
        repeat (20) @(posedge aclk);

        $display("%0d requests over %0d register settings, %0d results compared, %0d events",
                 requests_seen, settings_used, results_checked, events_seen);
        $display("idle patterns: sender 16%%/receiver 47%%, then reversed, then none");
        if (pending_results != 0)
            $display("%0d expected results never arrived", pending_results);
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // far beyond the slowest legal run of about a thousand requests
    initial begin
        #1_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/kded_pkg.sv
rtl/kded_cfg_regs.sv
rtl/kded_front.sv
rtl/kded_queue.sv
rtl/kded_back.sv
rtl/key_debounce_event_detector.sv
tb/kded_event_checker.sv
tb/tb.sv
